>>> hdl/bffd_pkg.sv
`default_nettype none
// ============================================================================
// bffd_pkg
// Shared types and constants of the cubic B-spline displacement block.
// ============================================================================
package bffd_pkg;

    localparam int SPC_W     = 9;
    localparam int GIX_W     = 6;
    localparam int VOX_W     = 10;
    localparam int PIX_W     = 15;
    localparam int WGT_W     = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int IQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 2;

    localparam logic [2:0] REG_SPACING_X    = 3'd0;
    localparam logic [2:0] REG_SPACING_Y    = 3'd1;
    localparam logic [2:0] REG_SPACING_Z    = 3'd2;
    localparam logic [2:0] REG_GRID_COUNT_X = 3'd3;
    localparam logic [2:0] REG_GRID_COUNT_Y = 3'd4;
    localparam logic [2:0] REG_GRID_COUNT_Z = 3'd5;

    typedef struct packed {
        logic [2:0][SPC_W-1:0] spacing;
        logic [2:0][GIX_W-1:0] cmax;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic in_pop;
        logic res_push;
    } t_bk_stat;

endpackage
`default_nettype wire

>>> hdl/bffd_fifo.sv
`default_nettype none
// ============================================================================
// bffd_fifo
// Small register queue between the front, the back and the result side.
// ============================================================================
module bffd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

>>> hdl/bffd_front.sv
`default_nettype none
// ============================================================================
// bffd_front
// Configuration registers and intake: clamps and packs each item for the queue.
// ============================================================================
module bffd_front #(
    parameter int GRID_DIM    = 32,
    parameter int VOL_DIM     = 1024,
    parameter int SPACING_MAX = 64,
    parameter int COORD_WIDTH = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bffd_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [bffd_pkg::PDATA_W-1:0]      pwdata,
    output logic [bffd_pkg::PDATA_W-1:0]           prdata,
    input  wire logic                              i_kind,
    input  wire logic [bffd_pkg::PIX_W-1:0]        i_point_index,
    input  wire logic signed [COORD_WIDTH-1:0]     i_point_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_point_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_point_pos_z,
    input  wire logic [bffd_pkg::VOX_W-1:0]        i_voxel_x,
    input  wire logic [bffd_pkg::VOX_W-1:0]        i_voxel_y,
    input  wire logic [bffd_pkg::VOX_W-1:0]        i_voxel_z,
    output logic [2+$clog2(GRID_DIM*GRID_DIM*GRID_DIM)+3*COORD_WIDTH
                  +3*bffd_pkg::VOX_W-1:0]          o_entry,
    output bffd_pkg::t_cfg                         o_cfg
);
    import bffd_pkg::*;

    localparam int PTS    = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int LIDX_W = $clog2(PTS);

    logic [6:0]       r_spc [3];
    logic [5:0]       r_cnt [3];
    logic [2:0]       reg_sel;
    logic             ld_ok;
    logic [VOX_W-1:0] vx, vy, vz;

    function automatic logic [VOX_W-1:0] clamp_vox(input logic [VOX_W-1:0] v);
        if (32'(v) > VOL_DIM - 1) begin
            return VOX_W'(VOL_DIM - 1);
        end
        return v;
    endfunction

    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_spc[a] <= 7'd8;
                r_cnt[a] <= 6'd32;
            end
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_SPACING_X:    r_spc[0] <= pwdata[6:0];
                REG_SPACING_Y:    r_spc[1] <= pwdata[6:0];
                REG_SPACING_Z:    r_spc[2] <= pwdata[6:0];
                REG_GRID_COUNT_X: r_cnt[0] <= pwdata[5:0];
                REG_GRID_COUNT_Y: r_cnt[1] <= pwdata[5:0];
                REG_GRID_COUNT_Z: r_cnt[2] <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SPACING_X:    prdata = 32'(r_spc[0]);
            REG_SPACING_Y:    prdata = 32'(r_spc[1]);
            REG_SPACING_Z:    prdata = 32'(r_spc[2]);
            REG_GRID_COUNT_X: prdata = 32'(r_cnt[0]);
            REG_GRID_COUNT_Y: prdata = 32'(r_cnt[1]);
            REG_GRID_COUNT_Z: prdata = 32'(r_cnt[2]);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_spc[a] == '0) begin
                o_cfg.spacing[a] = SPC_W'(1);
            end else if (32'(r_spc[a]) > SPACING_MAX) begin
                o_cfg.spacing[a] = SPC_W'(SPACING_MAX);
            end else begin
                o_cfg.spacing[a] = SPC_W'(r_spc[a]);
            end
            if (r_cnt[a] == '0) begin
                o_cfg.cmax[a] = '0;
            end else if (32'(r_cnt[a]) > GRID_DIM) begin
                o_cfg.cmax[a] = GIX_W'(GRID_DIM - 1);
            end else begin
                o_cfg.cmax[a] = r_cnt[a] - 1'b1;
            end
        end
    end

    assign ld_ok = (32'(i_point_index) < PTS);
    assign vx    = clamp_vox(i_voxel_x);
    assign vy    = clamp_vox(i_voxel_y);
    assign vz    = clamp_vox(i_voxel_z);

    assign o_entry = {i_kind, ld_ok, LIDX_W'(i_point_index),
                      i_point_pos_x, i_point_pos_y, i_point_pos_z, vx, vy, vz};

endmodule
`default_nettype wire

>>> hdl/bffd_back.sv
`default_nettype none
// ============================================================================
// bffd_back
// Control-point store and query engine: segment divide, weight divide,
// 64-tap weighted sum and saturating finish.
// ============================================================================
module bffd_back #(
    parameter int GRID_DIM    = 32,
    parameter int COORD_WIDTH = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  bffd_pkg::t_cfg                     i_cfg,
    input  wire logic [2+$clog2(GRID_DIM*GRID_DIM*GRID_DIM)+3*COORD_WIDTH
                       +3*bffd_pkg::VOX_W-1:0] i_entry,
    input  wire logic                          i_in_empty,
    output logic                               o_in_pop,
    input  wire logic                          i_out_full,
    output logic                               o_res_push,
    output logic [3*COORD_WIDTH-1:0]           o_res,
    output bffd_pkg::t_bk_stat                 o_stat
);
    import bffd_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int PTS    = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int LIDX_W = $clog2(PTS);
    localparam int GW     = $clog2(GRID_DIM);
    localparam int C_W    = 3 * SPC_W;
    localparam int B_W    = C_W + 3;
    localparam int NUM_W  = B_W + WGT_W;
    localparam int PW     = CW + WGT_W + 1;
    localparam int AW     = PW + 6;
    localparam int SW     = AW - 15;
    localparam int E_P    = 3 * VOX_W;
    localparam int E_I    = E_P + 3 * CW;
    localparam int ENT_W  = 2 + LIDX_W + 3 * CW + 3 * VOX_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'(1) << (CW - 1)) - 64'(1));
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_POLY1 = 10'b0000000100,
        S_POLY2 = 10'b0000001000,
        S_POLY3 = 10'b0000010000,
        S_WDIV  = 10'b0000100000,
        S_MAC   = 10'b0001000000,
        S_DRAIN = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_PUSH  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_step;
    logic       r_v1, r_v2, r_v3;

    logic                     e_kind, e_ld_ok;
    logic [LIDX_W-1:0]        e_idx;
    logic signed [CW-1:0]     e_px, e_py, e_pz;
    logic [VOX_W-1:0]         e_v [3];

    logic signed [CW-1:0] mem_x [PTS];
    logic signed [CW-1:0] mem_y [PTS];
    logic signed [CW-1:0] mem_z [PTS];

    logic [VOX_W-1:0]   r_vox  [3];
    logic [SPC_W-1:0]   r_drem [3];
    logic [VOX_W-1:0]   r_dlo  [3];
    logic [2*SPC_W-1:0] r_r2 [3], r_d2 [3], r_rd [3], r_dr2 [3];
    logic [SPC_W-1:0]   r_dr [3];
    logic [C_W-1:0]     r_r3 [3], r_d3 [3], r_r2d [3], r_rd2 [3], r_dr3 [3];
    logic [GW-1:0]      r_idx [3][4];
    logic [B_W-1:0]     r_den [3];
    logic [B_W-1:0]     r_wrem [3][4];
    logic [WGT_W-1:0]   r_wlo  [3][4];

    logic [WGT_W-1:0]      r_wxy, r_wz1, r_wf;
    logic signed [CW-1:0]  r_qx, r_qy, r_qz, r_px2, r_py2, r_pz2;
    logic signed [PW-1:0]  r_prx, r_pry, r_prz;
    logic signed [AW-1:0]  r_acc [3];
    logic signed [CW-1:0]  r_res [3];

    logic [1:0]        sa, sb, sc;
    logic [LIDX_W-1:0] rd_addr;
    logic [31:0]       wxy_full, wf_full;
    logic              issue;

    assign e_kind  = i_entry[ENT_W-1];
    assign e_ld_ok = i_entry[ENT_W-2];
    assign e_idx   = i_entry[E_I+LIDX_W-1:E_I];
    assign e_px    = i_entry[E_P+3*CW-1:E_P+2*CW];
    assign e_py    = i_entry[E_P+2*CW-1:E_P+CW];
    assign e_pz    = i_entry[E_P+CW-1:E_P];
    assign e_v[0]  = i_entry[3*VOX_W-1:2*VOX_W];
    assign e_v[1]  = i_entry[2*VOX_W-1:VOX_W];
    assign e_v[2]  = i_entry[VOX_W-1:0];

    assign o_in_pop   = (r_state == S_IDLE) && !i_in_empty;
    assign o_res_push = (r_state == S_PUSH) && !i_out_full;
    assign o_res      = {r_res[0], r_res[1], r_res[2]};
    assign o_stat     = '{busy: (r_state != S_IDLE), in_pop: o_in_pop,
                          res_push: o_res_push};

    assign issue = (r_state == S_MAC);
    assign sa    = r_step[5:4];
    assign sb    = r_step[3:2];
    assign sc    = r_step[1:0];
    assign rd_addr = LIDX_W'(32'(r_idx[0][sa]) + 32'(r_idx[1][sb]) * GRID_DIM
                            + 32'(r_idx[2][sc]) * (GRID_DIM * GRID_DIM));
    assign wxy_full = 32'(r_wlo[0][sa]) * 32'(r_wlo[1][sb]) + 32'd32768;
    assign wf_full  = 32'(r_wxy) * 32'(r_wz1) + 32'd32768;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (o_in_pop && e_kind) n_state = S_DIV;
            S_DIV:   if (r_step == 7'(VOX_W - 1)) n_state = S_POLY1;
            S_POLY1: n_state = S_POLY2;
            S_POLY2: n_state = S_POLY3;
            S_POLY3: n_state = S_WDIV;
            S_WDIV:  if (r_step == 7'(WGT_W - 1)) n_state = S_MAC;
            S_MAC:   if (r_step == 7'd63) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !r_v2 && !r_v3) n_state = S_FIN;
            S_FIN:   n_state = S_PUSH;
            S_PUSH:  if (!i_out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? '0 : r_step + 1'b1;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_pop && !e_kind && e_ld_ok) begin
            mem_x[e_idx] <= e_px;
            mem_y[e_idx] <= e_py;
            mem_z[e_idx] <= e_pz;
        end
        r_qx <= mem_x[rd_addr];
        r_qy <= mem_y[rd_addr];
        r_qz <= mem_z[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        logic [SPC_W:0]   t;
        logic [B_W:0]     tw;
        logic [SPC_W-1:0] d;
        logic [VOX_W:0]   p;
        logic [B_W:0]     b1, b2;
        logic [B_W-1:0]   bk [4];
        logic [NUM_W-1:0] num;
        case (r_state)
            S_IDLE: begin
                for (int a = 0; a < 3; a++) begin
                    r_vox[a]  <= e_v[a];
                    r_dlo[a]  <= e_v[a];
                    r_drem[a] <= '0;
                    r_acc[a]  <= '0;
                end
            end
            S_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    d = i_cfg.spacing[a];
                    t = {r_drem[a], r_dlo[a][VOX_W-1]};
                    if (t >= {1'b0, d}) begin
                        r_drem[a] <= SPC_W'(t - {1'b0, d});
                        r_dlo[a]  <= {r_dlo[a][VOX_W-2:0], 1'b1};
                    end else begin
                        r_drem[a] <= t[SPC_W-1:0];
                        r_dlo[a]  <= {r_dlo[a][VOX_W-2:0], 1'b0};
                    end
                end
            end
            S_POLY1: begin
                for (int a = 0; a < 3; a++) begin
                    d = i_cfg.spacing[a];
                    r_r2[a]  <= r_drem[a] * r_drem[a];
                    r_d2[a]  <= d * d;
                    r_rd[a]  <= r_drem[a] * d;
                    r_dr[a]  <= d - r_drem[a];
                    r_dr2[a] <= (d - r_drem[a]) * (d - r_drem[a]);
                    for (int k = 0; k < 4; k++) begin
                        p = {1'b0, r_dlo[a]} + (VOX_W + 1)'(k);
                        if (p > (VOX_W + 1)'(i_cfg.cmax[a])) begin
                            r_idx[a][k] <= GW'(i_cfg.cmax[a]);
                        end else begin
                            r_idx[a][k] <= GW'(p);
                        end
                    end
                end
            end
            S_POLY2: begin
                for (int a = 0; a < 3; a++) begin
                    d = i_cfg.spacing[a];
                    r_r3[a]  <= r_r2[a] * r_drem[a];
                    r_d3[a]  <= r_d2[a] * d;
                    r_r2d[a] <= r_r2[a] * d;
                    r_rd2[a] <= r_rd[a] * d;
                    r_dr3[a] <= r_dr2[a] * r_dr[a];
                end
            end
            S_POLY3: begin
                for (int a = 0; a < 3; a++) begin
                    b1 = 3 * (B_W + 1)'(r_r3[a]) + 4 * (B_W + 1)'(r_d3[a])
                       - 6 * (B_W + 1)'(r_r2d[a]);
                    b2 = 3 * (B_W + 1)'(r_r2d[a]) + 3 * (B_W + 1)'(r_rd2[a])
                       + (B_W + 1)'(r_d3[a]) - 3 * (B_W + 1)'(r_r3[a]);
                    bk[0] = B_W'(r_dr3[a]);
                    bk[1] = B_W'(b1);
                    bk[2] = B_W'(b2);
                    bk[3] = B_W'(r_r3[a]);
                    r_den[a] <= B_W'(6 * B_W'(r_d3[a]));
                    for (int k = 0; k < 4; k++) begin
                        num = {bk[k], WGT_W'(0)} + NUM_W'(3 * NUM_W'(r_d3[a]));
                        r_wrem[a][k] <= num[NUM_W-1:WGT_W];
                        r_wlo[a][k]  <= num[WGT_W-1:0];
                    end
                end
            end
            S_WDIV: begin
                for (int a = 0; a < 3; a++) begin
                    for (int k = 0; k < 4; k++) begin
                        tw = {r_wrem[a][k], r_wlo[a][k][WGT_W-1]};
                        if (tw >= {1'b0, r_den[a]}) begin
                            r_wrem[a][k] <= B_W'(tw - {1'b0, r_den[a]});
                            r_wlo[a][k]  <= {r_wlo[a][k][WGT_W-2:0], 1'b1};
                        end else begin
                            r_wrem[a][k] <= tw[B_W-1:0];
                            r_wlo[a][k]  <= {r_wlo[a][k][WGT_W-2:0], 1'b0};
                        end
                    end
                end
            end
            S_FIN: begin
                for (int a = 0; a < 3; a++) begin
                    logic signed [AW-1:0] ar;
                    logic signed [SW-1:0] v;
                    ar = r_acc[a] + AW'(32768);
                    v  = SW'($signed(ar[AW-1:16])) - $signed(SW'({r_vox[a], 8'b0}));
                    if (v > SAT_HI) begin
                        r_res[a] <= SAT_HI[CW-1:0];
                    end else if (v < SAT_LO) begin
                        r_res[a] <= SAT_LO[CW-1:0];
                    end else begin
                        r_res[a] <= v[CW-1:0];
                    end
                end
            end
            default: ;
        endcase
        r_wxy <= wxy_full[31:16];
        r_wz1 <= r_wlo[2][sc];
        r_wf  <= wf_full[31:16];
        r_px2 <= r_qx;
        r_py2 <= r_qy;
        r_pz2 <= r_qz;
        r_prx <= $signed({1'b0, r_wf}) * r_px2;
        r_pry <= $signed({1'b0, r_wf}) * r_py2;
        r_prz <= $signed({1'b0, r_wf}) * r_pz2;
        if (r_v3) begin
            r_acc[0] <= r_acc[0] + AW'(r_prx);
            r_acc[1] <= r_acc[1] + AW'(r_pry);
            r_acc[2] <= r_acc[2] + AW'(r_prz);
        end
    end

endmodule
`default_nettype wire

>>> hdl/bspline_ffd_displacement_3d.sv
`default_nettype none
// ============================================================================
// bspline_ffd_displacement_3d
// Cubic B-spline free-form deformation: control-point store and per-voxel
// displacement query.
// ============================================================================
// A load item with an in-range index goes into the store as the back end takes
// it. A query runs in order through the per-axis segment divide, the spline
// polynomials, the weight divide, the control-point reads (one read per cycle
// from each coordinate memory) and the pipeline drain, then finishes, rounds
// and hands over the result. A four-entry queue in front and a two-entry queue
// behind let intake and result delivery run while a query is in progress.
// The store has no reset; query only points that have been loaded.
module bspline_ffd_displacement_3d #(
    parameter int GRID_DIM    = 32,
    parameter int VOL_DIM     = 1024,
    parameter int SPACING_MAX = 64,
    parameter int COORD_WIDTH = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bffd_pkg::PDATA_W-1:0]  pwdata,
    output logic [bffd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_kind,
    input  wire logic [bffd_pkg::PIX_W-1:0]    i_point_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_pos_z,
    input  wire logic [bffd_pkg::VOX_W-1:0]    i_voxel_x,
    input  wire logic [bffd_pkg::VOX_W-1:0]    i_voxel_y,
    input  wire logic [bffd_pkg::VOX_W-1:0]    i_voxel_z,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [COORD_WIDTH-1:0]      o_disp_x,
    output logic signed [COORD_WIDTH-1:0]      o_disp_y,
    output logic signed [COORD_WIDTH-1:0]      o_disp_z
);
    import bffd_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int LIDX_W = $clog2(GRID_DIM * GRID_DIM * GRID_DIM);
    localparam int ENT_W  = 2 + LIDX_W + 3 * CW + 3 * VOX_W;

    logic [ENT_W-1:0]  w_entry, w_q_entry;
    logic              w_q_empty, w_q_pop, w_out_full, w_res_push;
    logic [3*CW-1:0]   w_res, w_out;
    t_cfg              w_cfg;
    t_bk_stat          w_stat;

    assign pready = 1'b1;

    bffd_front #(
        .GRID_DIM    (GRID_DIM),
        .VOL_DIM     (VOL_DIM),
        .SPACING_MAX (SPACING_MAX),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_kind        (i_kind),
        .i_point_index (i_point_index),
        .i_point_pos_x (i_point_pos_x),
        .i_point_pos_y (i_point_pos_y),
        .i_point_pos_z (i_point_pos_z),
        .i_voxel_x     (i_voxel_x),
        .i_voxel_y     (i_voxel_y),
        .i_voxel_z     (i_voxel_z),
        .o_entry       (w_entry),
        .o_cfg         (w_cfg)
    );

    bffd_fifo #(.WIDTH(ENT_W), .DEPTH(IQ_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_entry),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_entry),
        .o_empty (w_q_empty)
    );

    bffd_back #(
        .GRID_DIM    (GRID_DIM),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_entry    (w_q_entry),
        .i_in_empty (w_q_empty),
        .o_in_pop   (w_q_pop),
        .i_out_full (w_out_full),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .o_stat     (w_stat)
    );

    bffd_fifo #(.WIDTH(3 * CW), .DEPTH(OQ_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_rdata (w_out),
        .o_empty (empty)
    );

    assign o_disp_x = w_out[3*CW-1:2*CW];
    assign o_disp_y = w_out[2*CW-1:CW];
    assign o_disp_z = w_out[CW-1:0];

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |-> !w_out_full)
        else $error("result pushed into full queue");

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.in_pop |-> !w_q_empty && !w_stat.busy)
        else $error("item taken while busy or queue empty");

    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |-> w_stat.busy && !w_stat.in_pop)
        else $error("result pushed outside a query");

    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |=> !w_stat.busy)
        else $error("back end still busy after result");

endmodule
`default_nettype wire
